// File: src/eaf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eaf_pkg
// Shared types and constants for the elliptical aperture flux block:
// register layout, controller-to-datapath command encoding and field widths.
// ----------------------------------------------------------------------------
package eaf_pkg;

   // Field widths fixed by the interface
   localparam int CFG_BITS       = 16;
   localparam int BASE_BITS      = 40;
   localparam int FLUX_BITS      = 48;
   localparam int COUNT_BITS     = 24;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 40;
   localparam int FRAC_BITS      = 4;

   // Multiplier digit layout for the exact inside test
   localparam int DIGIT_BITS = 16;
   localparam int DIG_COUNT  = 4;
   localparam int AB_BITS    = 2 * CFG_BITS;
   localparam int AREA_SHIFT = 28;   // aligns a^2 b^2 (Q.16) with u^2 b^2 (Q.44)

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_AXIS_U   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_AXIS_V   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROT_COS  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROT_SIN  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SKY      = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BASE     = 3'd7;

   // Multiplier wide operand select
   localparam logic [2:0] X_DX   = 3'd0;
   localparam logic [2:0] X_DY   = 3'd1;
   localparam logic [2:0] X_UMAG = 3'd2;
   localparam logic [2:0] X_VMAG = 3'd3;
   localparam logic [2:0] X_AXU  = 3'd4;
   localparam logic [2:0] X_UB   = 3'd5;
   localparam logic [2:0] X_VA   = 3'd6;
   localparam logic [2:0] X_AB   = 3'd7;

   // Multiplier digit operand select
   localparam logic [2:0] Y_COS = 3'd0;
   localparam logic [2:0] Y_SIN = 3'd1;
   localparam logic [2:0] Y_AXU = 3'd2;
   localparam logic [2:0] Y_AXV = 3'd3;
   localparam logic [2:0] Y_UBD = 3'd4;
   localparam logic [2:0] Y_VAD = 3'd5;
   localparam logic [2:0] Y_ABD = 3'd6;

   // Accumulator operations
   localparam logic [1:0] ACC_HOLD  = 2'd0;
   localparam logic [1:0] ACC_LOAD  = 2'd1;
   localparam logic [1:0] ACC_ADD   = 2'd2;
   localparam logic [1:0] ACC_SHIFT = 2'd3;

   // Accumulator store targets
   localparam logic [2:0] ST_NONE = 3'd0;
   localparam logic [2:0] ST_U    = 3'd1;
   localparam logic [2:0] ST_V    = 3'd2;
   localparam logic [2:0] ST_UB   = 3'd3;
   localparam logic [2:0] ST_VA   = 3'd4;
   localparam logic [2:0] ST_AB   = 3'd5;

   typedef struct packed {
      logic [CFG_BITS-1:0]  center_x;
      logic [CFG_BITS-1:0]  center_y;
      logic [CFG_BITS-1:0]  axis_u;
      logic [CFG_BITS-1:0]  axis_v;
      logic [CFG_BITS-1:0]  rotation_cos;
      logic [CFG_BITS-1:0]  rotation_sin;
      logic [CFG_BITS-1:0]  sky_level;
      logic [BASE_BITS-1:0] base_flux;
   } cfg_type;

   typedef struct packed {
      logic       capture;
      logic [2:0] x_sel;
      logic [2:0] y_sel;
      logic [1:0] digit;
      logic       negate;
      logic [1:0] acc_op;
      logic [2:0] store;
      logic       update;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic final_pixel;
   } status_type;

endpackage
`default_nettype wire

// File: src/eaf_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eaf_csr
// Configuration register file. Takes one write beat per cycle, by index.
// ----------------------------------------------------------------------------
module eaf_csr import eaf_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data,
   output cfg_type                        cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_CENTER_X: cfg_in.center_x     = csr_data[CFG_BITS-1:0];
            REG_CENTER_Y: cfg_in.center_y     = csr_data[CFG_BITS-1:0];
            REG_AXIS_U:   cfg_in.axis_u       = csr_data[CFG_BITS-1:0];
            REG_AXIS_V:   cfg_in.axis_v       = csr_data[CFG_BITS-1:0];
            REG_ROT_COS:  cfg_in.rotation_cos = csr_data[CFG_BITS-1:0];
            REG_ROT_SIN:  cfg_in.rotation_sin = csr_data[CFG_BITS-1:0];
            REG_SKY:      cfg_in.sky_level    = csr_data[CFG_BITS-1:0];
            REG_BASE:     cfg_in.base_flux    = csr_data[BASE_BITS-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x     <= '0;
         cfg_ff.center_y     <= '0;
         cfg_ff.axis_u       <= 16'd16;      // 1.0 in Q12.4
         cfg_ff.axis_v       <= 16'd16;
         cfg_ff.rotation_cos <= 16'd16384;   // 1.0 in Q1.14
         cfg_ff.rotation_sin <= '0;
         cfg_ff.sky_level    <= '0;
         cfg_ff.base_flux    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// File: src/eaf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eaf_ctrl
// Sequencer for one pixel: issues the multiply/accumulate schedule of the
// rotation, scaling and exact inside test, then the sum update and result.
// ----------------------------------------------------------------------------
module eaf_ctrl import eaf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  status_type       status,
   output cmd_type          cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_RUN    = 2'd1;
   localparam logic [1:0] S_UPDATE = 2'd2;
   localparam logic [1:0] S_EMIT   = 2'd3;

   localparam logic [4:0] LAST_STEP = 5'd19;

   logic [1:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   cmd_type    run_cmd;

   function automatic cmd_type mul_cmd(input logic [2:0] xs, input logic [2:0] ys,
                                       input logic [1:0] dg, input logic ng,
                                       input logic [1:0] op, input logic [2:0] st);
      cmd_type c;
      c        = '0;
      c.x_sel  = xs;
      c.y_sel  = ys;
      c.digit  = dg;
      c.negate = ng;
      c.acc_op = op;
      c.store  = st;
      return c;
   endfunction

   // Multiply schedule; each product passes through the product register into the accumulator
   always_comb begin
      run_cmd        = '0;
      run_cmd.acc_op = ACC_HOLD;
      run_cmd.store  = ST_NONE;
      case (step_ff)
         // u = dx*cos + dy*sin, v = dy*cos - dx*sin
         5'd0:  run_cmd = mul_cmd(X_DX, Y_COS, 2'd0, 1'b0, ACC_LOAD, ST_NONE);
         5'd1:  run_cmd = mul_cmd(X_DY, Y_SIN, 2'd0, 1'b0, ACC_ADD, ST_NONE);
         5'd2:  run_cmd = mul_cmd(X_DY, Y_COS, 2'd0, 1'b0, ACC_LOAD, ST_NONE);
         5'd3:  run_cmd = mul_cmd(X_DX, Y_SIN, 2'd0, 1'b1, ACC_ADD, ST_U);
         // |u|*b, a*b, |v|*a
         5'd4:  run_cmd = mul_cmd(X_UMAG, Y_AXV, 2'd0, 1'b0, ACC_LOAD, ST_NONE);
         5'd5:  run_cmd = mul_cmd(X_AXU, Y_AXV, 2'd0, 1'b0, ACC_LOAD, ST_V);
         5'd6:  run_cmd = mul_cmd(X_VMAG, Y_AXU, 2'd0, 1'b0, ACC_LOAD, ST_UB);
         // (ub^2 + va^2 - ab^2 << 28), one digit at a time, top digit first
         5'd7:  run_cmd = mul_cmd(X_UB, Y_UBD, 2'd3, 1'b0, ACC_LOAD, ST_AB);
         5'd8:  run_cmd = mul_cmd(X_AB, Y_ABD, 2'd3, 1'b1, ACC_ADD, ST_VA);
         5'd9:  run_cmd = mul_cmd(X_VA, Y_VAD, 2'd3, 1'b0, ACC_ADD, ST_NONE);
         5'd10: run_cmd = mul_cmd(X_UB, Y_UBD, 2'd2, 1'b0, ACC_SHIFT, ST_NONE);
         5'd11: run_cmd = mul_cmd(X_AB, Y_ABD, 2'd2, 1'b1, ACC_ADD, ST_NONE);
         5'd12: run_cmd = mul_cmd(X_VA, Y_VAD, 2'd2, 1'b0, ACC_ADD, ST_NONE);
         5'd13: run_cmd = mul_cmd(X_UB, Y_UBD, 2'd1, 1'b0, ACC_SHIFT, ST_NONE);
         5'd14: run_cmd = mul_cmd(X_AB, Y_ABD, 2'd1, 1'b1, ACC_ADD, ST_NONE);
         5'd15: run_cmd = mul_cmd(X_VA, Y_VAD, 2'd1, 1'b0, ACC_ADD, ST_NONE);
         5'd16: run_cmd = mul_cmd(X_UB, Y_UBD, 2'd0, 1'b0, ACC_SHIFT, ST_NONE);
         5'd17: run_cmd = mul_cmd(X_AB, Y_ABD, 2'd0, 1'b1, ACC_ADD, ST_NONE);
         5'd18: run_cmd = mul_cmd(X_VA, Y_VAD, 2'd0, 1'b0, ACC_ADD, ST_NONE);
         default: begin
            run_cmd.acc_op = ACC_HOLD;
         end
      endcase
   end

   // State machine
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.acc_op   = ACC_HOLD;
      cmd.store    = ST_NONE;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               step_in     = '0;
               state_in    = S_RUN;
            end
         end
         S_RUN: begin
            cmd     = run_cmd;
            step_in = step_ff + 5'd1;
            if (step_ff == LAST_STEP) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.final_pixel ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: src/eaf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eaf_datapath
// Pixel offset capture, one shared multiplier with a signed accumulator for
// the rotation and the exact ellipse test, saturating flux sum and count,
// and the result register.
// ----------------------------------------------------------------------------
module eaf_datapath import eaf_pkg::*; #(
   parameter int COORD_BITS = 12,
   parameter int LEVEL_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  cfg_type                    cfg,
   input  wire logic [COORD_BITS-1:0] req_pixel_col,
   input  wire logic [COORD_BITS-1:0] req_pixel_row,
   input  wire logic [LEVEL_BITS-1:0] req_pixel_level,
   input  wire logic                  req_final_pixel,
   output logic [FLUX_BITS-1:0]       total_flux,
   output logic [COUNT_BITS-1:0]      inside_count
);

   // Offset magnitude, rotated magnitude, scaled magnitude, accumulator widths
   localparam int POS_BITS = COORD_BITS + FRAC_BITS;
   localparam int DMW      = (POS_BITS > CFG_BITS) ? POS_BITS : CFG_BITS;
   localparam int UMW      = DMW + CFG_BITS;
   localparam int BW       = UMW + CFG_BITS;
   localparam int PW       = BW + DIGIT_BITS;
   localparam int AW       = 2 * BW + 2;
   localparam int YW       = DIG_COUNT * DIGIT_BITS;
   localparam int LW       = ((LEVEL_BITS > CFG_BITS) ? LEVEL_BITS : CFG_BITS) + 1;
   localparam int SW       = FLUX_BITS + 1;

   function automatic logic [FLUX_BITS-1:0] sat_flux(input logic [SW-1:0] s);
      logic [FLUX_BITS-1:0] r;
      if (s[SW-1] != s[SW-2]) begin
         r = s[SW-1] ? {1'b1, {(FLUX_BITS-1){1'b0}}} : {1'b0, {(FLUX_BITS-1){1'b1}}};
      end else begin
         r = s[FLUX_BITS-1:0];
      end
      return r;
   endfunction

   logic [DMW-1:0]        dx_mag_ff, dx_mag_in, dy_mag_ff, dy_mag_in;
   logic                  dx_neg_ff, dx_neg_in, dy_neg_ff, dy_neg_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic                  final_ff, final_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic                  prod_neg_ff, prod_neg_in;
   logic [1:0]            acc_op_ff;
   logic [AW-1:0]         acc_ff, acc_in;
   logic [UMW-1:0]        umag_ff, umag_in, vmag_ff, vmag_in;
   logic [BW-1:0]         ub_ff, ub_in, va_ff, va_in;
   logic [AB_BITS-1:0]    ab_ff, ab_in;
   logic [FLUX_BITS-1:0]  flux_ff, flux_in, out_flux_ff, out_flux_in;
   logic [COUNT_BITS-1:0] tally_ff, tally_in, out_count_ff, out_count_in;

   logic [DMW:0]          dx_diff, dy_diff;
   logic [CFG_BITS-1:0]   cos_mag, sin_mag;
   logic [BW-1:0]         x_op;
   logic [DIGIT_BITS-1:0] y_op;
   logic                  x_neg, y_neg;
   logic [YW-1:0]         ub_digits, va_digits, ab_digits;
   logic [AW-1:0]         prod_ext, term, acc_mag;
   logic                  in_ellipse;
   logic [LW-1:0]         pix_diff;
   logic [SW-1:0]         flux_next, total_next;

   // Pixel offsets from the center, Q.4, as sign and magnitude
   always_comb begin
      dx_diff = {{(DMW + 1 - POS_BITS){1'b0}}, req_pixel_col, {FRAC_BITS{1'b0}}}
              - {{(DMW + 1 - CFG_BITS){1'b0}}, cfg.center_x};
      dy_diff = {{(DMW + 1 - POS_BITS){1'b0}}, req_pixel_row, {FRAC_BITS{1'b0}}}
              - {{(DMW + 1 - CFG_BITS){1'b0}}, cfg.center_y};
      dx_neg_in = dx_neg_ff;
      dy_neg_in = dy_neg_ff;
      dx_mag_in = dx_mag_ff;
      dy_mag_in = dy_mag_ff;
      level_in  = level_ff;
      final_in  = final_ff;
      if (cmd.capture) begin
         dx_neg_in = dx_diff[DMW];
         dy_neg_in = dy_diff[DMW];
         dx_mag_in = dx_diff[DMW] ? DMW'(-dx_diff) : dx_diff[DMW-1:0];
         dy_mag_in = dy_diff[DMW] ? DMW'(-dy_diff) : dy_diff[DMW-1:0];
         level_in  = req_pixel_level;
         final_in  = req_final_pixel;
      end
   end

   // Operand select for the shared multiplier
   always_comb begin
      cos_mag   = cfg.rotation_cos[CFG_BITS-1] ? (CFG_BITS'(0) - cfg.rotation_cos)
                                               : cfg.rotation_cos;
      sin_mag   = cfg.rotation_sin[CFG_BITS-1] ? (CFG_BITS'(0) - cfg.rotation_sin)
                                               : cfg.rotation_sin;
      ub_digits = {{(YW - BW){1'b0}}, ub_ff};
      va_digits = {{(YW - BW){1'b0}}, va_ff};
      ab_digits = {{(YW - AB_BITS - AREA_SHIFT){1'b0}}, ab_ff, {AREA_SHIFT{1'b0}}};

      case (cmd.x_sel)
         X_DX:    x_op = {{(BW - DMW){1'b0}}, dx_mag_ff};
         X_DY:    x_op = {{(BW - DMW){1'b0}}, dy_mag_ff};
         X_UMAG:  x_op = {{(BW - UMW){1'b0}}, umag_ff};
         X_VMAG:  x_op = {{(BW - UMW){1'b0}}, vmag_ff};
         X_AXU:   x_op = {{(BW - CFG_BITS){1'b0}}, cfg.axis_u};
         X_UB:    x_op = ub_ff;
         X_VA:    x_op = va_ff;
         X_AB:    x_op = {{(BW - AB_BITS){1'b0}}, ab_ff};
         default: x_op = '0;
      endcase

      case (cmd.y_sel)
         Y_COS:   y_op = cos_mag;
         Y_SIN:   y_op = sin_mag;
         Y_AXU:   y_op = cfg.axis_u;
         Y_AXV:   y_op = cfg.axis_v;
         Y_UBD:   y_op = ub_digits[cmd.digit * DIGIT_BITS +: DIGIT_BITS];
         Y_VAD:   y_op = va_digits[cmd.digit * DIGIT_BITS +: DIGIT_BITS];
         Y_ABD:   y_op = ab_digits[cmd.digit * DIGIT_BITS +: DIGIT_BITS];
         default: y_op = '0;
      endcase

      x_neg = ((cmd.x_sel == X_DX) && dx_neg_ff) || ((cmd.x_sel == X_DY) && dy_neg_ff);
      y_neg = ((cmd.y_sel == Y_COS) && cfg.rotation_cos[CFG_BITS-1])
           || ((cmd.y_sel == Y_SIN) && cfg.rotation_sin[CFG_BITS-1]);
      prod_in     = {{(PW - BW){1'b0}}, x_op} * {{(PW - DIGIT_BITS){1'b0}}, y_op};
      prod_neg_in = x_neg ^ y_neg ^ cmd.negate;
   end

   // Accumulator: hold, load, add, or shift one digit up and add
   always_comb begin
      prod_ext = {{(AW - PW){1'b0}}, prod_ff};
      term     = prod_neg_ff ? (AW'(0) - prod_ext) : prod_ext;
      case (acc_op_ff)
         ACC_HOLD:  acc_in = acc_ff;
         ACC_LOAD:  acc_in = term;
         ACC_ADD:   acc_in = acc_ff + term;
         ACC_SHIFT: acc_in = (acc_ff << DIGIT_BITS) + term;
         default:   acc_in = acc_ff;
      endcase
   end

   // Stores of intermediate magnitudes from the accumulator
   always_comb begin
      acc_mag = acc_ff[AW-1] ? (AW'(0) - acc_ff) : acc_ff;
      umag_in = umag_ff;
      vmag_in = vmag_ff;
      ub_in   = ub_ff;
      va_in   = va_ff;
      ab_in   = ab_ff;
      case (cmd.store)
         ST_NONE: umag_in = umag_ff;
         ST_U:    umag_in = acc_mag[UMW-1:0];
         ST_V:    vmag_in = acc_mag[UMW-1:0];
         ST_UB:   ub_in   = acc_mag[BW-1:0];
         ST_VA:   va_in   = acc_mag[BW-1:0];
         ST_AB:   ab_in   = acc_mag[AB_BITS-1:0];
         default: umag_in = umag_ff;
      endcase
   end

   // Saturating sum and count, result capture
   always_comb begin
      in_ellipse = acc_ff[AW-1];
      pix_diff   = {{(LW - LEVEL_BITS){1'b0}}, level_ff} - {{(LW - CFG_BITS){1'b0}}, cfg.sky_level};
      flux_next  = {flux_ff[FLUX_BITS-1], flux_ff} + {{(SW - LW){pix_diff[LW-1]}}, pix_diff};
      total_next = {flux_ff[FLUX_BITS-1], flux_ff}
                 + {{(SW - BASE_BITS){cfg.base_flux[BASE_BITS-1]}}, cfg.base_flux};
      flux_in      = flux_ff;
      tally_in     = tally_ff;
      out_flux_in  = out_flux_ff;
      out_count_in = out_count_ff;
      if (cmd.update && in_ellipse) begin
         flux_in = sat_flux(flux_next);
         if (tally_ff != {COUNT_BITS{1'b1}}) begin
            tally_in = tally_ff + COUNT_BITS'(1);
         end
      end
      if (cmd.emit) begin
         out_flux_in  = sat_flux(total_next);
         out_count_in = tally_ff;
         flux_in      = '0;
         tally_in     = '0;
      end
   end

   assign status.final_pixel = final_ff;
   assign total_flux         = out_flux_ff;
   assign inside_count       = out_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_op_ff <= ACC_HOLD;
         flux_ff   <= '0;
         tally_ff  <= '0;
      end else begin
         acc_op_ff <= cmd.acc_op;
         flux_ff   <= flux_in;
         tally_ff  <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_mag_ff    <= dx_mag_in;
      dy_mag_ff    <= dy_mag_in;
      dx_neg_ff    <= dx_neg_in;
      dy_neg_ff    <= dy_neg_in;
      level_ff     <= level_in;
      final_ff     <= final_in;
      prod_ff      <= prod_in;
      prod_neg_ff  <= prod_neg_in;
      acc_ff       <= acc_in;
      umag_ff      <= umag_in;
      vmag_ff      <= vmag_in;
      ub_ff        <= ub_in;
      va_ff        <= va_in;
      ab_ff        <= ab_in;
      out_flux_ff  <= out_flux_in;
      out_count_ff <= out_count_in;
   end

endmodule
`default_nettype wire

// File: src/elliptical_aperture_flux.sv
`default_nettype none
// ----------------------------------------------------------------------------
// elliptical_aperture_flux
// Sums sky-subtracted pixel levels inside a rotated ellipse and counts the
// inside pixels; the last pixel of a scan returns base flux plus the sum.
// ----------------------------------------------------------------------------
// Each pixel beat occupies the block from taking the pixel through the
// sum update: the exact inside test issues 19 products in sequence through
// one multiplier of 48x16 bits ((COORD_BITS+36)x16 for coordinates wider
// than 12 bits) and a signed accumulator, the last product passes through
// the product register into the accumulator, and the sum update follows.
// The final pixel also loads the result. req_ready is high only between
// pixels. The result sits in an output register until taken, while the
// next pixels are already being worked on; a final pixel waits only if the
// previous result has not yet been taken. Configuration writes are taken in
// any cycle and must be made while no pixel is in progress. No clearing
// pass follows reset.
// ----------------------------------------------------------------------------
module elliptical_aperture_flux import eaf_pkg::*; #(
   parameter int COORD_BITS = 12,
   parameter int LEVEL_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [COORD_BITS-1:0]       req_pixel_col,
   input  wire logic [COORD_BITS-1:0]       req_pixel_row,
   input  wire logic [LEVEL_BITS-1:0]       req_pixel_level,
   input  wire logic                        req_final_pixel,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [FLUX_BITS-1:0]      rsp_total_flux,
   output logic [COUNT_BITS-1:0]            rsp_inside_count,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]    csr_data
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   eaf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   eaf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   eaf_datapath #(
      .COORD_BITS (COORD_BITS),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .cfg             (cfg),
      .req_pixel_col   (req_pixel_col),
      .req_pixel_row   (req_pixel_row),
      .req_pixel_level (req_pixel_level),
      .req_final_pixel (req_final_pixel),
      .total_flux      (rsp_total_flux),
      .inside_count    (rsp_inside_count)
   );

endmodule
`default_nettype wire

// File: test/tb_elliptical_aperture_flux.sv
// ----------------------------------------------------------------------------
// tb_elliptical_aperture_flux
// Self-checking bench for the elliptical aperture flux block. A directed
// table covers reset values, boundary pixels, sky and base flux extremes, a
// zero axis and an unnormalized rotation. Random phases follow, each with a
// fresh ellipse and its own idle pattern. Every result beat is compared with
// a typed sum or a bit-exact flux and count predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_elliptical_aperture_flux;
   import eaf_pkg::*;

   localparam int COORD_W       = 12;
   localparam int LEVEL_W       = 16;
   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 32;     // outlasts the longest pixel
   localparam int QUIET_LIMIT   = 3000;
   localparam int PIXEL_GOAL    = 2000;
   localparam int PHASES        = 16;
   localparam int HOLD_PHASE    = 4;
   localparam int HOLD_CYCLES   = 600;
   localparam int TALLY_MAX     = 24'hFF_FFFF;
   localparam longint FLUX_MAX  = 64'sh7FFF_FFFF_FFFF;
   localparam longint FLUX_MIN  = -FLUX_MAX - 1;
   localparam bit TYPED         = 1'b1;
   localparam bit PREDICTED     = 1'b0;

   typedef struct packed {
      logic signed [FLUX_BITS-1:0] flux;
      logic [COUNT_BITS-1:0]       count;
   } aperture_sum_t;

   typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;
   typedef enum int {SHAPE_PLAIN, SHAPE_EXTREME, SHAPE_SKEWED} shape_t;

   typedef struct packed {
      row_kind_t                   kind;
      logic [CSR_INDEX_BITS-1:0]   index;
      logic [CSR_DATA_BITS-1:0]    data;
      logic [COORD_W-1:0]          col;
      logic [COORD_W-1:0]          pix_row;
      logic [LEVEL_W-1:0]          level;
      logic                        fin;
      logic                        typed;
      logic signed [FLUX_BITS-1:0] flux;
      logic [COUNT_BITS-1:0]       count;
   } stim_row_t;

   // Directed table: typed sums only where they follow from the reset ellipse
   // (unit radius at the origin), the sky value or the base flux extremes.
   stim_row_t directed_rows [39] = '{
      // reset ellipse: origin inside, unit-distance neighbors on the edge
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd0, 12'd0, 16'hFFFF, 1'b1, TYPED, 48'sd65535, 24'd1},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd1, 12'd0, 16'd9, 1'b1, TYPED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd0, 12'd1, 16'd9, 1'b1, TYPED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'hFFF, 12'hFFF, 16'hFFFF, 1'b1, TYPED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd0, 12'd0, 16'hFFFF, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd1, 12'd1, 16'd5, 1'b1, TYPED, 48'sd65535, 24'd2},
      // sky above the level, upper data bits dropped
      '{ROW_WRITE, REG_SKY, 40'hAB_CDEF_0064, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd0, 12'd0, 16'd50, 1'b1, TYPED, -48'sd50, 24'd1},
      // base flux extremes
      '{ROW_WRITE, REG_BASE, 40'h80_0000_0000, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd0, 12'd0, 16'd0, 1'b1, TYPED,
        -48'sd549755813988, 24'd1},
      '{ROW_WRITE, REG_BASE, 40'h7F_FFFF_FFFF, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd0, 12'd0, 16'hFFFF, 1'b1, TYPED,
        48'sd549755879322, 24'd1},
      // zero semi-axis: nothing is inside
      '{ROW_WRITE, REG_AXIS_U, 40'h0, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd0, 12'd0, 16'd7, 1'b1, TYPED,
        48'sd549755813887, 24'd0},
      // widest ellipse at the far corner
      '{ROW_WRITE, REG_BASE, 40'h0, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_WRITE, REG_SKY, 40'h0, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_WRITE, REG_AXIS_U, 40'hFFFF, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_WRITE, REG_AXIS_V, 40'hFFFF, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_WRITE, REG_CENTER_X, 40'hFFFF, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_WRITE, REG_CENTER_Y, 40'hFFFF, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'hFFF, 12'hFFF, 16'hFFFF, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd0, 12'd0, 16'hFFFF, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd0, 12'hFFF, 16'd1, 1'b1, PREDICTED, 48'sd0, 24'd0},
      // rotation far outside the unit circle
      '{ROW_WRITE, REG_ROT_COS, 40'h8000, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_WRITE, REG_ROT_SIN, 40'h7FFF, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'hFFF, 12'd4090, 16'd100, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd2048, 12'd2048, 16'd200, 1'b1, PREDICTED, 48'sd0, 24'd0},
      // rotated by -45 degrees at sqrt(2) scale, fractional center, 10 x 3 pixel axes
      '{ROW_WRITE, REG_ROT_COS, 40'h4000, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_WRITE, REG_ROT_SIN, 40'hC000, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_WRITE, REG_CENTER_X, 40'h0808, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_WRITE, REG_CENTER_Y, 40'h0800, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_WRITE, REG_AXIS_U, 40'h00A0, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_WRITE, REG_AXIS_V, 40'h0030, 12'd0, 12'd0, 16'd0, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd128, 12'd128, 16'd1000, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd138, 12'd128, 16'd1000, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd128, 12'd138, 16'd1000, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'd129, 12'd131, 16'd1000, 1'b0, PREDICTED, 48'sd0, 24'd0},
      '{ROW_PIXEL, REG_CENTER_X, 40'h0, 12'hFFF, 12'd0, 16'hFFFF, 1'b1, PREDICTED, 48'sd0, 24'd0}
   };

   // Clock, reset and block inputs
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [COORD_W-1:0] req_pixel_col = '0;
   logic [COORD_W-1:0] req_pixel_row = '0;
   logic [LEVEL_W-1:0] req_pixel_level = '0;
   logic req_final_pixel = 1'b0;
   logic rsp_ready = 1'b0;
   logic csr_valid = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   logic req_ready;
   logic rsp_valid;
   logic signed [FLUX_BITS-1:0] rsp_total_flux;
   logic [COUNT_BITS-1:0] rsp_inside_count;
   logic csr_ready;

   // Predictor state: register copy, running sum and count
   cfg_type aper;
   longint flux_acc;
   int unsigned tally;
   aperture_sum_t pending_sums [$];

   int errors = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_ask = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   always #HALF_PERIOD clock = ~clock;

   elliptical_aperture_flux #(
      .COORD_BITS (COORD_W),
      .LEVEL_BITS (LEVEL_W)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_col    (req_pixel_col),
      .req_pixel_row    (req_pixel_row),
      .req_pixel_level  (req_pixel_level),
      .req_final_pixel  (req_final_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_total_flux   (rsp_total_flux),
      .rsp_inside_count (rsp_inside_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d want %0d", what, got, want);
      errors++;
   endtask

   function automatic longint clamp_flux(input longint v);
      if (v > FLUX_MAX) return FLUX_MAX;
      if (v < FLUX_MIN) return FLUX_MIN;
      return v;
   endfunction

   // Exact strict inside test: u^2 b^2 + v^2 a^2 < a^2 b^2
   function automatic bit pixel_in_aperture(input logic [COORD_W-1:0] col, pix_row);
      longint dx, dy, cs, sn, u, v;
      logic [63:0] mu, mv;
      logic [127:0] ub, va, ab;
      dx = longint'({48'h0, col, 4'h0}) - longint'({48'h0, aper.center_x});
      dy = longint'({48'h0, pix_row, 4'h0}) - longint'({48'h0, aper.center_y});
      cs = longint'(signed'(aper.rotation_cos));
      sn = longint'(signed'(aper.rotation_sin));
      u = dx * cs + dy * sn;
      v = dy * cs - dx * sn;
      mu = (u < 0) ? -u : u;
      mv = (v < 0) ? -v : v;
      ub = {64'h0, mu} * {112'h0, aper.axis_v};
      va = {64'h0, mv} * {112'h0, aper.axis_u};
      ab = {112'h0, aper.axis_u} * {112'h0, aper.axis_v};
      // area term is Q.16, left side Q.44
      return (ub * ub + va * va) < ((ab * ab) << 28);
   endfunction

   // Sum and count update; returns 1 when the pixel closes a scan
   function automatic bit accumulate_pixel(input logic [COORD_W-1:0] col, pix_row,
                                           input logic [LEVEL_W-1:0] level, input logic fin,
                                           output aperture_sum_t total);
      longint sum;
      total = '0;
      if (pixel_in_aperture(col, pix_row)) begin
         flux_acc = clamp_flux(flux_acc + longint'({48'h0, level})
                               - longint'({48'h0, aper.sky_level}));
         if (tally != TALLY_MAX) tally++;
      end
      if (!fin) return 1'b0;
      sum = clamp_flux(flux_acc + longint'(signed'(aper.base_flux)));
      total.flux = sum[FLUX_BITS-1:0];
      total.count = tally[COUNT_BITS-1:0];
      flux_acc = 0;
      tally = 0;
      return 1'b1;
   endfunction

   // One pixel beat, with random sender gaps ahead of it
   task automatic send_pixel(input logic [COORD_W-1:0] col, pix_row,
                             input logic [LEVEL_W-1:0] level, input logic fin,
                             input bit typed, input aperture_sum_t typed_sum);
      aperture_sum_t predicted;
      bit emits;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_col <= col;
      req_pixel_row <= pix_row;
      req_pixel_level <= level;
      req_final_pixel <= fin;
      do @(posedge clock); while (!req_ready);
      emits = accumulate_pixel(col, pix_row, level, fin, predicted);
      if (emits) pending_sums.push_back(typed ? typed_sum : predicted);
   endtask

   // Register write once all sums are out and the last pixel has settled
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      req_valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         REG_CENTER_X: aper.center_x = data[CFG_BITS-1:0];
         REG_CENTER_Y: aper.center_y = data[CFG_BITS-1:0];
         REG_AXIS_U:   aper.axis_u = data[CFG_BITS-1:0];
         REG_AXIS_V:   aper.axis_v = data[CFG_BITS-1:0];
         REG_ROT_COS:  aper.rotation_cos = data[CFG_BITS-1:0];
         REG_ROT_SIN:  aper.rotation_sin = data[CFG_BITS-1:0];
         REG_SKY:      aper.sky_level = data[CFG_BITS-1:0];
         REG_BASE:     aper.base_flux = data[BASE_BITS-1:0];
         default: ;
      endcase
   endtask

   // New ellipse, sky and base for a random phase
   task automatic pick_aperture(input shape_t shape);
      logic [15:0] cxv, cyv, au, av, cs, sn, skyv;
      logic [39:0] basev;
      cxv = 16'($urandom);
      cyv = 16'($urandom);
      au = 16'($urandom_range(400, 8));
      av = 16'($urandom_range(400, 8));
      skyv = ($urandom_range(1) == 0) ? 16'($urandom_range(3000)) : 16'($urandom);
      basev = {8'($urandom), 32'($urandom)};
      case ($urandom_range(7))
         0: {cs, sn} = {16'sd16384, 16'sd0};
         1: {cs, sn} = {16'sd14189, 16'sd8192};
         2: {cs, sn} = {16'sd11585, 16'sd11585};
         3: {cs, sn} = {16'sd8192, 16'sd14189};
         4: {cs, sn} = {16'sd0, 16'sd16384};
         5: {cs, sn} = {-16'sd8192, 16'sd14189};
         6: {cs, sn} = {-16'sd11585, 16'sd11585};
         default: {cs, sn} = {-16'sd14189, 16'sd8192};
      endcase
      if ($urandom_range(1) == 1) sn = -sn;
      case (shape)
         SHAPE_EXTREME: begin
            cxv = ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
            cyv = ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
            case ($urandom_range(3))
               0: au = 16'h0000;
               1: au = 16'h0001;
               2: au = 16'hFFFF;
               default: ;
            endcase
            case ($urandom_range(3))
               0: av = 16'h0000;
               1: av = 16'h0001;
               2: av = 16'hFFFF;
               default: ;
            endcase
            case ($urandom_range(4))
               0: cs = 16'h8000;
               1: cs = 16'hC000;
               2: cs = 16'h0000;
               3: cs = 16'h4000;
               default: cs = 16'h7FFF;
            endcase
            case ($urandom_range(4))
               0: sn = 16'h8000;
               1: sn = 16'hC000;
               2: sn = 16'h0000;
               3: sn = 16'h4000;
               default: sn = 16'h7FFF;
            endcase
            skyv = ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
            case ($urandom_range(2))
               0: basev = 40'h80_0000_0000;
               1: basev = 40'h7F_FFFF_FFFF;
               default: basev = 40'h0;
            endcase
         end
         SHAPE_SKEWED: begin
            cs = 16'($urandom);
            sn = 16'($urandom);
         end
         default: ;
      endcase
      // upper data bits of the 16-bit registers are random and must be dropped by the block
      write_register(REG_CENTER_X, {24'($urandom), cxv});
      write_register(REG_CENTER_Y, {24'($urandom), cyv});
      write_register(REG_AXIS_U, {24'($urandom), au});
      write_register(REG_AXIS_V, {24'($urandom), av});
      write_register(REG_ROT_COS, {24'($urandom), cs});
      write_register(REG_ROT_SIN, {24'($urandom), sn});
      write_register(REG_SKY, {24'($urandom), skyv});
      write_register(REG_BASE, basev);
   endtask

   // Receiver: random stalls, plus one long hold on request
   always @(posedge clock) begin
      if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Result beats against the oldest predicted sum
   always @(posedge clock) begin : check_results
      aperture_sum_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_sums.size() == 0) begin
            report_mismatch("unexpected result, flux", longint'(rsp_total_flux), 0);
         end else begin
            want = pending_sums.pop_front();
            if (rsp_total_flux !== want.flux)
               report_mismatch("total_flux", longint'(rsp_total_flux), longint'(want.flux));
            if (rsp_inside_count !== want.count)
               report_mismatch("inside_count", longint'(rsp_inside_count),
                               longint'(want.count));
         end
      end
   end

   // Watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("elliptical_aperture_flux: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus
   initial begin
      stim_row_t r;
      int sent, target, scan_len, span;
      logic [COORD_W-1:0] col, pix_row;
      logic [LEVEL_W-1:0] level;
      bit stray;

      aper = '{center_x: 16'd0, center_y: 16'd0, axis_u: 16'd16, axis_v: 16'd16,
               rotation_cos: 16'd16384, rotation_sin: 16'd0, sky_level: 16'd0,
               base_flux: 40'd0};
      flux_acc = 0;
      tally = 0;
      sent = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < $size(directed_rows); i++) begin
         r = directed_rows[i];
         if (r.kind == ROW_WRITE)
            write_register(r.index, r.data);
         else
            send_pixel(r.col, r.pix_row, r.level, r.fin, r.typed,
                       aperture_sum_t'({r.flux, r.count}));
      end

      // random phases: new ellipse, idle pattern, then scans around the center
      for (int phase = 0; phase < PHASES; phase++) begin
         pick_aperture(shape_t'(phase % 3));
         case (phase % 4)
            0: begin send_idle_pct = 0; stall_pct <= 0; end
            1: begin send_idle_pct = 80; stall_pct <= 0; end
            2: begin send_idle_pct = 0; stall_pct <= 80; end
            default: begin send_idle_pct = 12; stall_pct <= 12; end
         endcase
         if (phase == HOLD_PHASE) hold_ask <= hold_ask + 1;
         span = ((aper.axis_u > aper.axis_v ? aper.axis_u : aper.axis_v) >> 4) + 3;
         if (span > 80) span = 80;
         target = sent + PIXEL_GOAL / PHASES;
         while (sent < target) begin
            scan_len = $urandom_range(24, 1);
            stray = ($urandom_range(9) == 0);
            for (int k = 0; k < scan_len; k++) begin
               if (stray || $urandom_range(19) == 0) begin
                  col = COORD_W'($urandom);
                  pix_row = COORD_W'($urandom);
               end else begin
                  col = COORD_W'(int'(aper.center_x >> 4) + int'($urandom_range(2 * span)) - span);
                  pix_row = COORD_W'(int'(aper.center_y >> 4) + int'($urandom_range(2 * span))
                                     - span);
               end
               case ($urandom_range(7))
                  0: level = '0;
                  1: level = '1;
                  default: level = LEVEL_W'($urandom);
               endcase
               send_pixel(col, pix_row, level, k == scan_len - 1, PREDICTED, '0);
               sent++;
            end
            // now and then the sender waits for every sum to come back
            if ($urandom_range(19) == 0 && pending_sums.size() != 0) begin
               req_valid <= 1'b0;
               while (pending_sums.size() != 0) @(posedge clock);
            end
         end
      end

      // drain, let the block settle, then conclude
      req_valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && pending_sums.size() == 0) begin
         $display("elliptical_aperture_flux: match");
      end else begin
         $display("elliptical_aperture_flux: mismatch");
      end
      $finish;
   end

endmodule
